FILE: design/rns_pkg.sv
package rns_pkg;

  localparam int DEF_MAX_ITEMS    = 64;
  localparam int DEF_SAMPLE_WIDTH = 32;
  localparam int SCORE_W          = 16;
  localparam int POS_W            = 6;
  // Fraction bits of the score numerator: 2 * 32768.
  localparam int FRAC_W           = 16;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RANK,
    ST_READ,
    ST_DIV
  } rns_state_t;

  typedef struct packed {
    logic ld_wr;
    logic absent_load;
    logic rank_start;
    logic emit_rd;
    logic out_load;
    logic group_clear;
  } rns_cmd_t;

  typedef struct packed {
    logic rank_done;
    logic div_done;
    logic emit_last;
    logic out_free;
  } rns_stat_t;

endpackage

FILE: design/rns_in_if.sv
interface rns_in_if #(parameter int SAMPLE_WIDTH = 32);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           last;
  logic                           no_data;

  modport source (output valid, sample, last, no_data, input ready);
  modport sink   (input valid, sample, last, no_data, output ready);
endinterface

FILE: design/rns_out_if.sv
interface rns_out_if;
  import rns_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] rank_score;
  logic [POS_W-1:0]          position;
  logic                      absent;
  logic                      overflow;
  logic                      done_res;

  modport source (output valid, rank_score, position, absent, overflow, done_res,
                  input ready);
  modport sink   (input valid, rank_score, position, absent, overflow, done_res,
                  output ready);
endinterface

FILE: design/rns_div.sv
module rns_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] sh_r, sh_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W:0]   trial;
  logic             qbit;

  // Restoring division, one quotient bit per cycle; the quotient shifts in
  // behind the numerator bits as they are consumed.
  always_comb begin
    trial   = {rem_r, sh_r[NUM_W-1]};
    qbit    = (trial >= {1'b0, den});
    rem_nxt = rem_r;
    sh_nxt  = sh_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = '0;
      sh_nxt  = num;
      cnt_nxt = CNT_W'(NUM_W);
    end else if (cnt_r != '0) begin
      rem_nxt = qbit ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      sh_nxt  = {sh_r[NUM_W-2:0], qbit};
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
  end

  assign busy = (cnt_r != '0);
  assign quo  = sh_r;
endmodule

FILE: design/rns_ctrl.sv
module rns_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  input  logic              in_no_data,
  output logic              in_ready,
  input  rns_pkg::rns_stat_t stat,
  output rns_pkg::rns_cmd_t  cmd
);
  import rns_pkg::*;

  rns_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          if (in_no_data) begin
            cmd.absent_load = 1'b1;
            cmd.group_clear = 1'b1;
          end else begin
            cmd.ld_wr = 1'b1;
            if (in_last) begin
              cmd.rank_start = 1'b1;
              state_nxt      = ST_RANK;
            end
          end
        end
      end
      ST_RANK: begin
        if (stat.rank_done) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done && stat.out_free) begin
          cmd.out_load = 1'b1;
          if (stat.emit_last) begin
            cmd.group_clear = 1'b1;
            state_nxt       = ST_LOAD;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end
endmodule

FILE: design/rns_dp.sv
module rns_dp #(
  parameter int MAX_ITEMS    = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rns_pkg::rns_cmd_t                    cmd,
  output rns_pkg::rns_stat_t                   stat,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [rns_pkg::SCORE_W-1:0]   out_rank_score,
  output logic [rns_pkg::POS_W-1:0]            out_position,
  output logic                                 out_absent,
  output logic                                 out_overflow,
  output logic                                 out_done_res
);
  import rns_pkg::*;

  localparam int CW    = $clog2(MAX_ITEMS + 1);
  localparam int IW    = $clog2(MAX_ITEMS);
  localparam int NUM_W = CW + FRAC_W + 2;
  localparam int DEN_W = CW + 2;

  logic signed [SAMPLE_WIDTH-1:0] store_mem [MAX_ITEMS];
  logic [IW-1:0]                  order_mem [MAX_ITEMS];

  logic [CW-1:0] fill_r, n_m1;
  logic          ovf_r;

  // Rank engine: issue side walks (i, j), compare side counts samples ahead of i.
  logic [CW-1:0]                  iss_i_r, iss_j_r, cmp_i_r, cmp_j_r, cnt_r, rank_w;
  logic                           iss_on_r, cmp_v_r, less;
  logic signed [SAMPLE_WIDTH-1:0] ka_r, kb_r;

  logic [CW-1:0]    r_r;
  logic [IW-1:0]    ord_q_r;
  logic [CW:0]      d_w;
  logic [CW+1:0]    tw_w, mag_w;
  logic             neg_w, neg_r;
  logic [NUM_W-1:0] num_w, quo;
  logic             div_busy;
  logic signed [SCORE_W-1:0] score_w;

  logic                      out_valid_r;
  logic signed [SCORE_W-1:0] score_r;
  logic [POS_W-1:0]          pos_r;
  logic                      absent_r, oflag_r, done_r;

  assign n_m1   = fill_r - CW'(1);
  assign less   = (kb_r < ka_r) || ((kb_r == ka_r) && (cmp_j_r < cmp_i_r));
  assign rank_w = cnt_r + CW'(less);

  always_ff @(posedge clk) begin
    if (cmd.ld_wr && (fill_r != CW'(MAX_ITEMS))) begin
      store_mem[fill_r[IW-1:0]] <= in_sample;
    end
    ka_r <= store_mem[iss_i_r[IW-1:0]];
    kb_r <= store_mem[iss_j_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmp_v_r && (cmp_j_r == n_m1)) begin
      order_mem[rank_w[IW-1:0]] <= cmp_i_r[IW-1:0];
    end
    if (cmd.emit_rd) begin
      ord_q_r <= order_mem[r_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      ovf_r    <= 1'b0;
      iss_on_r <= 1'b0;
      cmp_v_r  <= 1'b0;
    end else begin
      if (cmd.group_clear) begin
        fill_r <= '0;
        ovf_r  <= 1'b0;
      end else if (cmd.ld_wr) begin
        if (fill_r != CW'(MAX_ITEMS)) begin
          fill_r <= fill_r + CW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      cmp_v_r <= iss_on_r;
      if (cmd.rank_start) begin
        iss_on_r <= 1'b1;
      end else if (iss_on_r && (iss_j_r == n_m1) && (iss_i_r == n_m1)) begin
        iss_on_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_i_r <= iss_i_r;
    cmp_j_r <= iss_j_r;
    if (cmd.rank_start) begin
      iss_i_r <= '0;
      iss_j_r <= '0;
      cnt_r   <= '0;
      r_r     <= '0;
    end else begin
      if (iss_on_r) begin
        if (iss_j_r == n_m1) begin
          iss_j_r <= '0;
          iss_i_r <= iss_i_r + CW'(1);
        end else begin
          iss_j_r <= iss_j_r + CW'(1);
        end
      end
      if (cmp_v_r) begin
        cnt_r <= (cmp_j_r == n_m1) ? '0 : rank_w;
      end
      if (cmd.out_load) begin
        r_r <= r_r + CW'(1);
      end
    end
    if (cmd.emit_rd) begin
      neg_r <= neg_w;
    end
  end

  // Score numerator |2r-(n+1)| * 65536 + (n+1) over 2(n+1), r 1-based.
  assign d_w   = (CW+1)'(fill_r) + (CW+1)'(1);
  assign tw_w  = {(CW+1)'(r_r) + (CW+1)'(1), 1'b0};
  assign neg_w = (tw_w < {1'b0, d_w});
  assign mag_w = neg_w ? ({1'b0, d_w} - tw_w) : (tw_w - {1'b0, d_w});
  assign num_w = {mag_w, {FRAC_W{1'b0}}} + NUM_W'(d_w);

  rns_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.emit_rd),
    .num   (num_w),
    .den   ({d_w, 1'b0}),
    .busy  (div_busy),
    .quo   (quo)
  );

  always_comb begin
    if (neg_r) begin
      score_w = (quo > NUM_W'(32768)) ? 16'sh8000 : SCORE_W'(NUM_W'(0) - quo);
    end else begin
      score_w = (quo > NUM_W'(32767)) ? 16'sh7fff : SCORE_W'(quo);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load || cmd.absent_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.absent_load) begin
      score_r  <= '0;
      pos_r    <= '0;
      absent_r <= 1'b1;
      oflag_r  <= 1'b0;
      done_r   <= 1'b1;
    end else if (cmd.out_load) begin
      score_r  <= score_w;
      pos_r    <= POS_W'(ord_q_r);
      absent_r <= 1'b0;
      oflag_r  <= ovf_r;
      done_r   <= (r_r == n_m1);
    end
  end

  assign stat.rank_done = !iss_on_r && !cmp_v_r;
  assign stat.div_done  = !div_busy;
  assign stat.emit_last = (r_r == n_m1);
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_rank_score = score_r;
  assign out_position   = pos_r;
  assign out_absent     = absent_r;
  assign out_overflow   = oflag_r;
  assign out_done_res   = done_r;
endmodule

FILE: design/rank_normalize_sorter.sv
// Channel   Direction  Payload
// in_chan   sink       sample (signed), last, no_data
// out_chan  source     rank_score (signed Q1.15), position, absent, overflow, done_res
//
// Samples of a group transfer in at one per cycle while the output register is free;
// the group ends on last or no_data. Ranking walks every pair of stored samples
// through two memory read ports. Each result then needs one order-memory read,
// a bit-serial divide and a load into the output register.
// Reset is synchronous and active low; the sample memory needs no clearing pass.
// A stalled result holds in the output register; the next result and new input transfers wait.
module rank_normalize_sorter #(
  parameter int MAX_ITEMS    = rns_pkg::DEF_MAX_ITEMS,
  parameter int SAMPLE_WIDTH = rns_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  rns_in_if.sink   in_chan,
  rns_out_if.source out_chan
);
  import rns_pkg::*;

  rns_cmd_t  cmd;
  rns_stat_t stat;

  // The controller sequences load, rank and emit; it sees only handshake and status.
  rns_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_last    (in_chan.last),
    .in_no_data (in_chan.no_data),
    .in_ready   (in_chan.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // The datapath holds the sample and order memories, the rank counter,
  // the score divider and the output register.
  rns_dp #(
    .MAX_ITEMS    (MAX_ITEMS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_sample      (in_chan.sample),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_rank_score (out_chan.rank_score),
    .out_position   (out_chan.position),
    .out_absent     (out_chan.absent),
    .out_overflow   (out_chan.overflow),
    .out_done_res   (out_chan.done_res)
  );
endmodule

FILE: tb/sv/tb_rank_normalize_sorter.sv
module tb_rank_normalize_sorter;
  timeunit 1ns;
  timeprecision 1ps;

  import rns_pkg::*;

  localparam int CAP = DEF_MAX_ITEMS;
  localparam int WATCHDOG_LIMIT = 40000;

  // One expected ranked result, in the order the block emits them.
  typedef struct {
    logic signed [SCORE_W-1:0] rank_score;
    logic [POS_W-1:0]          position;
    logic                      absent;
    logic                      overflow;
    logic                      done_res;
  } rank_result_t;

  // One row of the directed table. When has_known is set, the row's first result
  // is also compared against the typed-in score and position, which can be
  // read straight off the definition.
  typedef struct {
    logic signed [31:0]        sample;
    logic                      last;
    logic                      no_data;
    logic                      has_known;
    logic signed [SCORE_W-1:0] known_score;
    logic [POS_W-1:0]          known_pos;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rns_in_if #(.SAMPLE_WIDTH(DEF_SAMPLE_WIDTH)) in_chan();
  rns_out_if out_chan();

  rank_normalize_sorter DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Predictor state: the samples of the group being loaded and the overflow mark.
  logic signed [31:0] group_samples[$];
  logic               group_overflow;
  rank_result_t       pending_ranks[$];
  rank_result_t       known_firsts[$];
  int                 known_index[$];
  int                 results_seen;
  int                 fail_count;
  int                 idle_cycles;
  int                 sent_items;
  bit                 quiet_tail;

  // Centered score (2r-n-1)/(n+1) in Q1.15, rounded half away from zero.
  function automatic logic signed [SCORE_W-1:0] centered_score(int r, int n);
    longint d, mag, q;
    bit neg;
    d = n + 1;
    neg = (2 * r) < d;
    mag = neg ? d - 2 * r : 2 * r - d;
    q = (2 * mag * 32768 + d) / (2 * d);
    if (neg) return (q > 32768) ? -16'sd32768 : SCORE_W'(-q);
    return (q > 32767) ? 16'sd32767 : SCORE_W'(q);
  endfunction

  // Applies one accepted input transfer to the predictor and queues results.
  task automatic rank_group_step(logic signed [31:0] s, logic lst, logic nd);
    int order[$];
    int n, j, tmp;
    rank_result_t r;
    if (nd) begin
      group_samples.delete();
      group_overflow = 1'b0;
      r = '{rank_score: '0, position: '0, absent: 1'b1, overflow: 1'b0, done_res: 1'b1};
      pending_ranks = {pending_ranks, r};
      return;
    end
    if (group_samples.size() < CAP) group_samples = {group_samples, s};
    else group_overflow = 1'b1;
    if (!lst) return;
    n = group_samples.size();
    // Stable insertion sort of load indices by signed value.
    for (int i = 0; i < n; i++) begin
      order = {order, i};
      j = i;
      while (j > 0 && group_samples[order[j-1]] > group_samples[i]) begin
        tmp = order[j];
        order[j] = order[j-1];
        order[j-1] = tmp;
        j--;
      end
    end
    for (int i = 0; i < n; i++) begin
      r.rank_score = centered_score(i + 1, n);
      r.position   = POS_W'(order[i]);
      r.absent     = 1'b0;
      r.overflow   = group_overflow;
      r.done_res   = (i == n - 1);
      pending_ranks = {pending_ranks, r};
    end
    group_samples.delete();
    group_overflow = 1'b0;
  endtask

  // Directed table: extremes, a single sample, ties, no-data cases.
  stim_row_t directed_rows[$];

  task automatic add_row(logic signed [31:0] s, logic lst, logic nd,
                         logic hk = 1'b0, logic signed [15:0] ks = '0,
                         logic [5:0] kp = '0);
    directed_rows = {directed_rows, stim_row_t'{s, lst, nd, hk, ks, kp}};
  endtask

  task automatic build_directed();
    // No data with nothing loaded gives one absent result.
    add_row(32'sd5, 1'b0, 1'b1, 1'b1, 16'sd0, 6'd0);
    // A single-sample group: rank 1 of 1 scores zero.
    add_row(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b1, 16'sd0, 6'd0);
    // Two samples at both extremes: the most negative ranks first at -1/3.
    add_row(32'h7FFF_FFFF, 1'b0, 1'b0);
    add_row(32'h8000_0000, 1'b1, 1'b0, 1'b1, -16'sd10923, 6'd1);
    // Ties keep load order.
    add_row(32'sd7, 1'b0, 1'b0);
    add_row(32'sd7, 1'b0, 1'b0);
    add_row(-32'sd1, 1'b0, 1'b0);
    add_row(32'sd7, 1'b1, 1'b0, 1'b1, -16'sd19661, 6'd2);
    // No data discards a partly loaded group; also with last set.
    add_row(32'sd3, 1'b0, 1'b0);
    add_row(32'sd4, 1'b1, 1'b1, 1'b1, 16'sd0, 6'd0);
    add_row(32'h5555_5555, 1'b0, 1'b0);
    add_row(32'hAAAA_AAAA, 1'b0, 1'b0);
    add_row(32'h0000_0000, 1'b0, 1'b0);
    add_row(32'hFFFF_FFFF, 1'b1, 1'b0);
  endtask

  // Drives one transfer on the input channel, with random idle bursts before it.
  task automatic send_sample(logic signed [31:0] s, logic lst, logic nd);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.sample  <= s;
    in_chan.last    <= lst;
    in_chan.no_data <= nd;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    rank_group_step(s, lst, nd);
    sent_items++;
    @(negedge clk);
  endtask

  // Sends one group of random content; a few overflow, a few end in no data.
  task automatic send_random_group();
    int n, pick;
    logic signed [31:0] s;
    pick = $urandom_range(0, 19);
    if (pick == 0) n = $urandom_range(CAP + 1, CAP + 6);
    else if (pick == 1) n = CAP;
    else n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: s = $urandom_range(0, 7) - 4;
        1: s = $urandom();
        2: s = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        default: s = $signed({16'($urandom_range(0, 65535)), 16'h0}) >>> $urandom_range(0, 16);
      endcase
      if ($urandom_range(0, 40) == 0) begin
        send_sample(s, 1'($urandom_range(0, 1)), 1'b1);
        return;
      end
      send_sample(s, i == n - 1, 1'b0);
    end
  endtask

  // Result side: random backpressure bursts, compare each transfer in order.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet_tail && $urandom_range(0, 6) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rank_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_ranks.size() == 0) begin
        $error("unexpected result: rank_score=%0d position=%0d",
               out_chan.rank_score, out_chan.position);
        fail_count++;
      end else begin
        want = pending_ranks.pop_front();
        if (out_chan.rank_score !== want.rank_score) begin
          $error("rank_score: expected %0d, got %0d", want.rank_score, out_chan.rank_score);
          fail_count++;
        end
        if (out_chan.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, out_chan.position);
          fail_count++;
        end
        if (out_chan.absent !== want.absent) begin
          $error("absent: expected %0b, got %0b", want.absent, out_chan.absent);
          fail_count++;
        end
        if (out_chan.overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, out_chan.overflow);
          fail_count++;
        end
        if (out_chan.done_res !== want.done_res) begin
          $error("done_res: expected %0b, got %0b", want.done_res, out_chan.done_res);
          fail_count++;
        end
      end
      // Typed-in values from the directed table for the first result of a row.
      if (known_index.size() > 0 && known_index[0] == results_seen) begin
        void'(known_index.pop_front());
        want = known_firsts.pop_front();
        if (out_chan.rank_score !== want.rank_score) begin
          $error("rank_score: expected %0d, got %0d", want.rank_score, out_chan.rank_score);
          fail_count++;
        end
        if (out_chan.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, out_chan.position);
          fail_count++;
        end
      end
      results_seen++;
    end
  end

  // The watchdog counts cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int queued;
    group_overflow = 1'b0;
    fail_count = 0;
    results_seen = 0;
    idle_cycles = 0;
    sent_items = 0;
    quiet_tail = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.sample = '0;
    in_chan.last = 1'b0;
    in_chan.no_data = 1'b0;
    build_directed();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      queued = pending_ranks.size() + results_seen;
      send_sample(directed_rows[i].sample, directed_rows[i].last, directed_rows[i].no_data);
      if (directed_rows[i].has_known) begin
        known_index = {known_index, queued};
        known_firsts = {known_firsts,
                        rank_result_t'{rank_score: directed_rows[i].known_score,
                                       position: directed_rows[i].known_pos,
                                       absent: 1'b0, overflow: 1'b0, done_res: 1'b0}};
      end
    end

    // Random groups until about 360 samples have gone in; the tail runs at full rate.
    while (sent_items < 360) begin
      if (sent_items > 300) quiet_tail = 1'b1;
      send_random_group();
    end
    in_chan.valid <= 1'b0;

    while (pending_ranks.size() > 0) @(posedge clk);
    repeat (CAP * CAP + 200) @(posedge clk);
    if (fail_count == 0 && pending_ranks.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
design/rns_pkg.sv
design/rns_in_if.sv
design/rns_out_if.sv
design/rns_div.sv
design/rns_ctrl.sv
design/rns_dp.sv
design/rank_normalize_sorter.sv
tb/sv/tb_rank_normalize_sorter.sv
